@@ design/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, codes and control structs of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // transaction field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int RD_ROW_W   = 5;
    localparam int RD_COL_W   = 7;
    localparam int CELL_W     = 16;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_ROW_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;

    // operations
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // characters and attributes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] RESET_TEXT_ATTR   = 8'h0F;
    localparam logic [7:0] RESET_BLANK_ATTR  = 8'h07;
    localparam logic [CELL_W-1:0] INIT_CELL  = {RESET_BLANK_ATTR, CH_SPACE};

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture transaction fields
        logic exec;        // apply item to cursor / write printed cell
        logic init_wr;     // reset clearing pass write
        logic fill_wr;     // blank fill write at sweep address
        logic copy_rd;     // scroll: read one row below sweep address
        logic copy_wr;     // scroll: write read data at sweep address
        logic sweep_zero;
        logic sweep_inc;
        logic out_load;    // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scroll;      // item passes the last row
        logic clear;       // item is a clear
        logic sweep_last;  // sweep at last cell
        logic copy_last;   // sweep at last cell of scroll copy
    } status_t;

endpackage

@@ design/tcw_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw request / response interfaces
// Valid/ready channels carrying console requests and their results.
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::OP_W-1:0]       operation;
    logic [tcw_pkg::CHAR_W-1:0]     char_code;
    logic [tcw_pkg::RD_ROW_W-1:0]   read_row;
    logic [tcw_pkg::RD_COL_W-1:0]   read_col;

    modport source (output valid, operation, char_code, read_row, read_col,
                    input ready);
    modport sink   (input valid, operation, char_code, read_row, read_col,
                    output ready);
endinterface

interface tcw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CELL_W-1:0]     cell_value;
    logic [tcw_pkg::CUR_COL_W-1:0]  cursor_col;
    logic [tcw_pkg::CUR_ROW_W-1:0]  cursor_row;
    logic                           scrolled;

    modport source (output valid, cell_value, cursor_col, cursor_row, scrolled,
                    input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, scrolled,
                    output ready);
endinterface

@@ design/tcw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clearing pass, item execution, scroll copy, blank fill, result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tcw_pkg::status_t  st,
    output tcw_pkg::cmd_t     cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_EXEC    = 3'd2;
    localparam logic [2:0] S_COPY_RD = 3'd3;
    localparam logic [2:0] S_COPY_WR = 3'd4;
    localparam logic [2:0] S_FILL    = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (st.sweep_last)
                begin
                    cmd.sweep_inc  = 1'b0;
                    cmd.sweep_zero = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (st.scroll)
                begin
                    cmd.sweep_zero = 1'b1;
                    state_next     = S_COPY_RD;
                end
                else if (st.clear)
                begin
                    cmd.sweep_zero = 1'b1;
                    state_next     = S_FILL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                // increment past the last copied cell lands on the bottom row
                cmd.copy_wr   = 1'b1;
                cmd.sweep_inc = 1'b1;
                state_next    = st.copy_last ? S_FILL : S_COPY_RD;
            end
            S_FILL:
            begin
                cmd.fill_wr   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/tcw_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, attribute registers, sweep counter, result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [tcw_pkg::OP_W-1:0]          operation,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::RD_ROW_W-1:0]      read_row,
    input  logic [tcw_pkg::RD_COL_W-1:0]      read_col,
    input  tcw_pkg::cmd_t                     cmd,
    output tcw_pkg::status_t                  st,
    output logic [tcw_pkg::CELL_W-1:0]        cell_value,
    output logic [tcw_pkg::CUR_COL_W-1:0]     cursor_col,
    output logic [tcw_pkg::CUR_ROW_W-1:0]     cursor_row,
    output logic                              scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [31:0]       ROWS_U     = 32'(ROWS);
    localparam logic [31:0]       COLS_U     = 32'(COLUMNS);

    logic [CELL_W-1:0]   mem [CELLS];

    logic [OP_W-1:0]     op_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic [RD_ROW_W-1:0] rr_reg;
    logic [RD_COL_W-1:0] rc_reg;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                scrolled_reg, scrolled_next;
    logic [7:0]          text_attr_reg, text_attr_next;
    logic [7:0]          blank_attr_reg, blank_attr_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic [CELL_W-1:0]   rd_data_reg;

    logic [CELL_W-1:0]    cell_out_reg;
    logic [CUR_COL_W-1:0] col_out_reg;
    logic [CUR_ROW_W-1:0] row_out_reg;
    logic                 scr_out_reg;

    logic                is_put, is_nl, is_cr, printable, row_adv, scroll_hit;
    logic                rd_ok;
    logic [ADDR_W-1:0]   cur_addr, rd_item_addr, raddr, waddr;
    logic [CELL_W-1:0]   wdata;
    logic                we;

    assign is_put     = (op_reg == OP_PUT);
    assign is_nl      = (ch_reg == CH_NEWLINE);
    assign is_cr      = (ch_reg == CH_RETURN);
    assign printable  = is_put && !is_nl && !is_cr;
    assign row_adv    = is_nl && is_put || printable && (col_reg == LAST_COL);
    assign scroll_hit = row_adv && (row_reg == LAST_ROW);

    assign cur_addr = ADDR_W'(row_reg) * ROW_STRIDE + ADDR_W'(col_reg);

    assign rd_ok = (op_reg == OP_READ) && (32'(rr_reg) < ROWS_U)
                   && (32'(rc_reg) < COLS_U);
    assign rd_item_addr = rd_ok ? ADDR_W'(rr_reg) * ROW_STRIDE + ADDR_W'(rc_reg)
                                : '0;
    assign raddr = cmd.copy_rd ? sweep_reg + ROW_STRIDE : rd_item_addr;

    assign st.scroll     = scroll_hit;
    assign st.clear      = (op_reg == OP_CLEAR);
    assign st.sweep_last = (sweep_reg == LAST_ADDR);
    assign st.copy_last  = (sweep_reg == LAST_COPY);

    // single write port
    always_comb
    begin
        we    = 1'b1;
        waddr = sweep_reg;
        wdata = {blank_attr_reg, CH_SPACE};
        if (cmd.init_wr)
        begin
            wdata = INIT_CELL;
        end
        else if (cmd.fill_wr)
        begin
            wdata = {blank_attr_reg, CH_SPACE};
        end
        else if (cmd.copy_wr)
        begin
            wdata = rd_data_reg;
        end
        else if (cmd.exec && printable)
        begin
            waddr = cur_addr;
            wdata = {text_attr_reg, ch_reg};
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        scrolled_next = scrolled_reg;
        if (cmd.exec)
        begin
            scrolled_next = scroll_hit;
            if (op_reg == OP_CLEAR)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (is_put)
            begin
                if (is_cr || row_adv)
                begin
                    col_next = '0;
                end
                else if (printable)
                begin
                    col_next = col_reg + 1'b1;
                end
                if (row_adv && !scroll_hit)
                begin
                    row_next = row_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_zero)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_inc)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_comb
    begin
        text_attr_next  = text_attr_reg;
        blank_attr_next = blank_attr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_ATTR:  text_attr_next  = cfg_wdata;
                REG_BLANK_ATTR: blank_attr_next = cfg_wdata;
                default:        text_attr_next  = text_attr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            scrolled_reg   <= 1'b0;
            text_attr_reg  <= RESET_TEXT_ATTR;
            blank_attr_reg <= RESET_BLANK_ATTR;
            sweep_reg      <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            scrolled_reg   <= scrolled_next;
            text_attr_reg  <= text_attr_next;
            blank_attr_reg <= blank_attr_next;
            sweep_reg      <= sweep_next;
        end
    end

    // transaction capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= operation;
            ch_reg <= char_code;
            rr_reg <= read_row;
            rc_reg <= read_col;
        end
        if (cmd.out_load)
        begin
            cell_out_reg <= rd_ok ? rd_data_reg : '0;
            col_out_reg  <= CUR_COL_W'(col_reg);
            row_out_reg  <= CUR_ROW_W'(row_reg);
            scr_out_reg  <= scrolled_reg;
        end
    end

    assign cell_value = cell_out_reg;
    assign cursor_col = col_out_reg;
    assign cursor_row = row_out_reg;
    assign scrolled   = scr_out_reg;

endmodule

@@ design/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text screen of ROWS x COLUMNS 16-bit cells with cursor, print, clear, read.
// ----------------------------------------------------------------------------
// Reset: attributes to 0x0F / 0x07, cursor home, then a clearing pass writes
//   0x0720 into all ROWS*COLUMNS cells; no request transaction is taken
//   during the pass.
// Print, newline, carriage return, read and the unused code pass through the
//   execute and finish states; the next request is taken as the result loads.
// A scroll reads then writes each copied cell (row r+1 -> row r) and then
//   blank-fills the bottom row; a clear blank-fills every cell.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    tcw_req_if.sink                         req,
    tcw_rsp_if.source                       rsp
);
    import tcw_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Controller: sequences the clearing pass, item execution, the scroll
    // copy (row r+1 -> row r, each cell read then written) and blank fills.
    // A request transaction is taken while the prior result still waits in
    // the output register.
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath: screen memory (one write, one registered read port),
    // cursor, attribute registers, sweep address and the result register.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .operation  (req.operation),
        .char_code  (req.char_code),
        .read_row   (req.read_row),
        .read_col   (req.read_col),
        .cmd        (cmd),
        .st         (st),
        .cell_value (rsp.cell_value),
        .cursor_col (rsp.cursor_col),
        .cursor_row (rsp.cursor_row),
        .scrolled   (rsp.scrolled)
    );

    // every accepted request is captured by the datapath
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> cmd.load_item)
        else $error("request accepted without capture");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !cmd.out_load)
        else $error("result overwritten while stalled");

    // a scroll leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.scrolled |->
            rsp.cursor_col == '0 && rsp.cursor_row == CUR_ROW_W'(ROWS - 1))
        else $error("scroll left cursor off the bottom row start");

    // reported cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> 32'(rsp.cursor_col) < 32'(COLUMNS)
                      && 32'(rsp.cursor_row) < 32'(ROWS))
        else $error("cursor outside screen");

endmodule
